@@ rtl/qs_pkg.sv @@
// ----------------------------------------------------------------------------
// qs_pkg: shared constants and types for the quicksort sorter
// Sizes of the value store, index widths and the queued item format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = IDX_W + 1;
    // signed range bounds need room for -1 and MAX_ITEMS
    localparam int POS_W       = IDX_W + 2;
    localparam int STACK_W     = 2 * IDX_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified input item as it waits in the queue
    typedef struct packed {
        logic                  last;
        logic [VALUE_BITS-1:0] value;
    } qs_item_t;

endpackage : qs_pkg

`default_nettype wire

@@ rtl/quicksort_sorter.sv @@
// ----------------------------------------------------------------------------
// quicksort_sorter: streaming batch sorter for signed 32-bit values
// Loads a batch ended by tlast, sorts it ascending by Lomuto quicksort,
// then sends the sorted batch with tlast on its final value.
// ----------------------------------------------------------------------------
// Values load at one per cycle while the queue holds items; after the last
// transfer each partition reads the pivot, compares and swaps through the
// range and places the pivot; a stack pop reloads a saved range. Results
// leave one at a time, each held until tready; ordered batches sort slower.
// Reset (aresetn low, synchronous) empties the queue, clears the count, the
// overflow flag and the range stack pointer; stored values are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_sorter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [qs_pkg::VALUE_BITS-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic                          s_axis_tlast,   // last of batch
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [qs_pkg::VALUE_BITS-1:0]      m_axis_tdata,   // [31:0] sorted_value
    output logic                               m_axis_tlast,   // last_out
    output logic [0:0]                         m_axis_tuser    // [0] overflow
);
    import qs_pkg::*;

    // items waiting between the input side and the sorting engine
    logic     item_valid;
    logic     item_pop;
    qs_item_t item;

    // front: accepts transfers and queues them; stalls only when the
    // queue is full, so it keeps taking items while the engine is busy
    qs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // back: stores the batch (extra values past capacity are dropped and
    // flagged on tuser), sorts in place, and drives the output register
    qs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule : quicksort_sorter

`default_nettype wire

@@ rtl/qs_ram.sv @@
// ----------------------------------------------------------------------------
// qs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule : qs_ram

`default_nettype wire

@@ rtl/qs_front.sv @@
// ----------------------------------------------------------------------------
// qs_front: input side of the sorter
// Takes stream transfers, tags them as values or end of batch, and holds
// them in a short queue until the sorting engine is ready for them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [qs_pkg::VALUE_BITS-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               item_valid,
    output qs_pkg::qs_item_t                   item,
    input  wire logic                          item_pop
);
    import qs_pkg::*;

    qs_item_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic [QPTR_W:0]     fill_next;
    logic                push;
    logic                pop;
    qs_item_t            in_item;

    assign s_axis_tready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign item_valid    = (fill_reg != '0);
    assign item          = queue_reg[rd_ptr_reg];

    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = item_pop && item_valid;

    assign in_item.value = s_axis_tdata;
    assign in_item.last  = s_axis_tlast;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule : qs_front

`default_nettype wire

@@ rtl/qs_back.sv @@
// ----------------------------------------------------------------------------
// qs_back: sorting engine
// Stores a batch, sorts it in place by Lomuto quicksort with a range stack,
// then streams the sorted values out through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qs_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    input  wire qs_pkg::qs_item_t              item,
    output logic                               item_pop,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [qs_pkg::VALUE_BITS-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic [0:0]                         m_axis_tuser
);
    import qs_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_POP_WAIT,
        ST_PV_RD,
        ST_PV_WAIT,
        ST_P_RD,
        ST_P_CMP,
        ST_P_WR2,
        ST_FIN_RD,
        ST_FIN_W1,
        ST_FIN_W2,
        ST_SPLIT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    dropped_reg;
    logic [CNT_W-1:0]        sp_reg;
    logic [CNT_W-1:0]        k_reg;
    logic signed [POS_W-1:0] lo_reg;
    logic signed [POS_W-1:0] hi_reg;
    logic signed [POS_W-1:0] j_reg;
    logic signed [POS_W-1:0] ip_reg;
    logic [VALUE_BITS-1:0]   pivot_reg;
    logic [VALUE_BITS-1:0]   tmp_reg;

    // value store: two copies share the write port, one read port each
    logic                    v_we;
    logic [IDX_W-1:0]        v_waddr;
    logic [VALUE_BITS-1:0]   v_wdata;
    logic [IDX_W-1:0]        va_raddr;
    logic [IDX_W-1:0]        vb_raddr;
    logic [VALUE_BITS-1:0]   va_rdata;
    logic [VALUE_BITS-1:0]   vb_rdata;

    logic                    s_we;
    logic [IDX_W-1:0]        s_waddr;
    logic [STACK_W-1:0]      s_wdata;
    logic [IDX_W-1:0]        s_raddr;
    logic [STACK_W-1:0]      s_rdata;

    logic                    has_room;
    logic [CNT_W-1:0]        n_final;
    logic signed [POS_W-1:0] p_plus;
    logic signed [POS_W-1:0] p_minus;
    logic                    left_small;
    logic                    is_less;
    logic signed [POS_W-1:0] j_plus;
    logic [CNT_W-1:0]        sp_minus;

    qs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_store_a (
        .aclk    (aclk),
        .wr_en   (v_we),
        .wr_addr (v_waddr),
        .wr_data (v_wdata),
        .rd_addr (va_raddr),
        .rd_data (va_rdata)
    );

    qs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_store_b (
        .aclk    (aclk),
        .wr_en   (v_we),
        .wr_addr (v_waddr),
        .wr_data (v_wdata),
        .rd_addr (vb_raddr),
        .rd_data (vb_rdata)
    );

    qs_ram #(.WIDTH(STACK_W), .DEPTH(MAX_ITEMS)) u_stack (
        .aclk    (aclk),
        .wr_en   (s_we),
        .wr_addr (s_waddr),
        .wr_data (s_wdata),
        .rd_addr (s_raddr),
        .rd_data (s_rdata)
    );

    assign has_room   = (count_reg < CNT_W'(MAX_ITEMS));
    assign n_final    = has_room ? (count_reg + 1'b1) : count_reg;
    assign p_plus     = ip_reg + POS_W'(1);
    assign p_minus    = ip_reg - POS_W'(1);
    assign left_small = (ip_reg - lo_reg) < (hi_reg - ip_reg);
    assign is_less    = $signed(va_rdata) < $signed(pivot_reg);
    assign j_plus     = j_reg + POS_W'(1);
    assign sp_minus   = sp_reg - 1'b1;
    assign item_pop   = (state_reg == ST_LOAD);

    // memory port control
    always_comb begin
        v_we     = 1'b0;
        v_waddr  = j_reg[IDX_W-1:0];
        v_wdata  = tmp_reg;
        va_raddr = j_reg[IDX_W-1:0];
        vb_raddr = ip_reg[IDX_W-1:0];
        s_we     = 1'b0;
        s_waddr  = sp_reg[IDX_W-1:0];
        s_wdata  = {p_plus[IDX_W-1:0], hi_reg[IDX_W-1:0]};
        s_raddr  = sp_minus[IDX_W-1:0];
        unique case (state_reg)
            ST_LOAD: begin
                v_we    = item_valid && has_room;
                v_waddr = count_reg[IDX_W-1:0];
                v_wdata = item.value;
            end
            ST_PV_RD: begin
                va_raddr = hi_reg[IDX_W-1:0];
            end
            ST_P_CMP: begin
                // smaller value moves forward to the swap slot
                v_we    = is_less;
                v_waddr = ip_reg[IDX_W-1:0];
                v_wdata = va_rdata;
            end
            ST_P_WR2: begin
                v_we    = 1'b1;
                v_waddr = j_reg[IDX_W-1:0];
                v_wdata = tmp_reg;
            end
            ST_FIN_W1: begin
                v_we    = 1'b1;
                v_waddr = hi_reg[IDX_W-1:0];
                v_wdata = vb_rdata;
            end
            ST_FIN_W2: begin
                v_we    = 1'b1;
                v_waddr = ip_reg[IDX_W-1:0];
                v_wdata = pivot_reg;
            end
            ST_SPLIT: begin
                // push the larger side, keep working the smaller one
                s_we = (sp_reg < CNT_W'(MAX_ITEMS)) &&
                       (left_small ? (hi_reg > p_plus) : (p_minus > lo_reg));
                s_wdata = left_small ? {p_plus[IDX_W-1:0], hi_reg[IDX_W-1:0]}
                                     : {lo_reg[IDX_W-1:0], p_minus[IDX_W-1:0]};
            end
            ST_OUT_RD: begin
                va_raddr = k_reg[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            sp_reg        <= '0;
            k_reg         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (item_valid) begin
                        if (has_room) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (item.last) begin
                            lo_reg    <= '0;
                            hi_reg    <= $signed({1'b0, n_final}) - POS_W'(1);
                            sp_reg    <= '0;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (hi_reg > lo_reg) begin
                        state_reg <= ST_PV_RD;
                    end else if (sp_reg != '0) begin
                        sp_reg    <= sp_minus;
                        state_reg <= ST_POP_WAIT;
                    end else begin
                        k_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end
                end
                ST_POP_WAIT: begin
                    lo_reg    <= POS_W'(s_rdata[STACK_W-1 -: IDX_W]);
                    hi_reg    <= POS_W'(s_rdata[IDX_W-1:0]);
                    state_reg <= ST_CHECK;
                end
                ST_PV_RD: begin
                    state_reg <= ST_PV_WAIT;
                end
                ST_PV_WAIT: begin
                    pivot_reg <= va_rdata;
                    j_reg     <= lo_reg;
                    ip_reg    <= lo_reg;
                    state_reg <= ST_P_RD;
                end
                ST_P_RD: begin
                    state_reg <= ST_P_CMP;
                end
                ST_P_CMP: begin
                    if (is_less) begin
                        tmp_reg   <= vb_rdata;
                        state_reg <= ST_P_WR2;
                    end else begin
                        j_reg     <= j_plus;
                        state_reg <= (j_plus == hi_reg) ? ST_FIN_RD : ST_P_RD;
                    end
                end
                ST_P_WR2: begin
                    ip_reg    <= p_plus;
                    j_reg     <= j_plus;
                    state_reg <= (j_plus == hi_reg) ? ST_FIN_RD : ST_P_RD;
                end
                ST_FIN_RD: begin
                    state_reg <= ST_FIN_W1;
                end
                ST_FIN_W1: begin
                    state_reg <= ST_FIN_W2;
                end
                ST_FIN_W2: begin
                    state_reg <= ST_SPLIT;
                end
                ST_SPLIT: begin
                    if (s_we) begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                    if (left_small) begin
                        hi_reg <= p_minus;
                    end else begin
                        lo_reg <= p_plus;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    m_axis_tdata  <= va_rdata;
                    m_axis_tlast  <= (k_reg + 1'b1 == count_reg);
                    m_axis_tuser  <= dropped_reg;
                    m_axis_tvalid <= 1'b1;
                    state_reg     <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        if (m_axis_tlast) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= ST_LOAD;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule : qs_back

`default_nettype wire
